@@ rtl/core/gsct_pkg.sv @@
`timescale 1ns / 1ps

package gsct_pkg;

   localparam int CORDIC_STAGES = 24;
   localparam int SQRT_STAGES   = 32;
   // input reg, 3 angle conversion, init, rotation chain, sincos, 2 product,
   // vector init, root chain, half-angle chain, scale, output
   localparam int LATENCY       = 43 + 2 * CORDIC_STAGES;

   localparam logic signed [63:0] GAIN_Q30  = 64'sd652032874;
   localparam logic signed [63:0] ONE_Q30   = 64'sd1073741824;
   localparam logic [31:0]        QUARTER   = 32'h4000_0000;
   localparam logic [31:0]        HALF_TURN = 32'h8000_0000;
   localparam logic [16:0]        FULL_CDEG = 17'd36000;
   localparam logic [30:0]        ARC_SCALE = 31'd1280965555;

   localparam logic [31:0] ATAN_TAB [32] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
      32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
      32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
      32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001,
      32'h00000000, 32'h00000000
   };

   typedef enum logic [2:0] {
      CSR_CENTER_LAT     = 3'd0,
      CSR_CENTER_LON     = 3'd1,
      CSR_RADIUS_M       = 3'd2,
      CSR_START_ANGLE    = 3'd3,
      CSR_END_ANGLE      = 3'd4,
      CSR_HEADING_OFFSET = 3'd5,
      CSR_SECTOR_MODE    = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic signed [30:0] point_lat;
      logic signed [31:0] point_lon;
   } req_data_type;

   typedef struct packed {
      logic [24:0] range_m;
      logic [15:0] bearing_cdeg;
      logic        in_circle;
      logic        in_sector;
   } rsp_data_type;

   typedef struct packed {
      logic signed [63:0] x;
      logic signed [63:0] y;
      logic signed [33:0] z;
   } cordic_type;

   typedef struct packed {
      logic [63:0] rem;
      logic [63:0] root;
   } sqrt_type;

endpackage

@@ rtl/core/gsct_bin.sv @@
`timescale 1ns / 1ps

// 1e-7 degree to binary angle, round(v * 2^32 / 3.6e9), three stages
module gsct_bin import gsct_pkg::*; (
   input  logic               clock,
   input  logic signed [31:0] value,
   output logic [31:0]        angle
);

   localparam logic [64:0] RECIP  = 65'd5124095576;
   localparam logic [63:0] TURN   = 64'd3600000000;
   localparam logic [63:0] HALF_T = 64'd1800000000;

   logic        neg1_ff, neg1_in, neg2_ff;
   logic [31:0] mag1_ff, mag1_in;
   logic [31:0] q01_ff, q01_in, q02_ff;
   logic [33:0] rem2_ff, rem2_in;
   logic [31:0] angle_ff, angle_in;
   logic [64:0] prod;
   logic [63:0] num;
   logic [63:0] rem;
   logic [31:0] q;

   always_comb begin
      neg1_in = value[31];
      mag1_in = neg1_in ? 32'(-value) : 32'(value);
      prod    = 65'(mag1_in) * RECIP;
      q01_in  = prod[63:32];
   end

   always_comb begin
      num     = {mag1_ff, 32'b0} + HALF_T;
      rem     = num - 64'(q01_ff) * TURN;
      rem2_in = rem[33:0];
   end

   // estimate is low by at most two
   always_comb begin
      if (64'(rem2_ff) >= 2 * TURN) begin
         q = q02_ff + 32'd2;
      end else if (64'(rem2_ff) >= TURN) begin
         q = q02_ff + 32'd1;
      end else begin
         q = q02_ff;
      end
      angle_in = neg2_ff ? 32'(32'd0 - q) : q;
   end

   always_ff @(posedge clock) begin
      neg1_ff  <= neg1_in;
      mag1_ff  <= mag1_in;
      q01_ff   <= q01_in;
      neg2_ff  <= neg1_ff;
      q02_ff   <= q01_ff;
      rem2_ff  <= rem2_in;
      angle_ff <= angle_in;
   end

   assign angle = angle_ff;

endmodule

@@ rtl/core/gsct_cordic_cell.sv @@
`timescale 1ns / 1ps

module gsct_cordic_cell import gsct_pkg::*; (
   input  logic       clock,
   input  logic       rot_mode,
   input  logic [4:0] stage_idx,
   input  cordic_type d_in,
   output cordic_type d_out
);

   logic signed [63:0] xi, yi, dx, dy;
   logic signed [33:0] zi, atn;
   logic               hold, sub;
   cordic_type         d_ff, d_in_nxt;

   always_comb begin
      xi   = d_in.x;
      yi   = d_in.y;
      zi   = d_in.z;
      dx   = yi >>> stage_idx;
      dy   = xi >>> stage_idx;
      atn  = signed'({2'b00, ATAN_TAB[stage_idx]});
      // vectoring leaves a vector already on the axis alone
      hold = !rot_mode && (yi == 64'sd0);
      sub  = rot_mode ? !zi[33] : yi[63];
      d_in_nxt = d_in;
      if (!hold) begin
         if (sub) begin
            d_in_nxt.x = xi - dx;
            d_in_nxt.y = yi + dy;
            d_in_nxt.z = zi - atn;
         end else begin
            d_in_nxt.x = xi + dx;
            d_in_nxt.y = yi - dy;
            d_in_nxt.z = zi + atn;
         end
      end
   end

   always_ff @(posedge clock) begin
      d_ff <= d_in_nxt;
   end

   assign d_out = d_ff;

endmodule

@@ rtl/core/gsct_sqrt_cell.sv @@
`timescale 1ns / 1ps

// one result bit of an exact floor square root
module gsct_sqrt_cell import gsct_pkg::*; (
   input  logic       clock,
   input  logic [4:0] stage_idx,
   input  sqrt_type   d_in,
   output sqrt_type   d_out
);

   logic [63:0] bit_v, trial;
   sqrt_type    d_ff, d_in_nxt;

   always_comb begin
      bit_v = 64'd1 << {stage_idx, 1'b0};
      trial = d_in.root + bit_v;
      if (d_in.rem >= trial) begin
         d_in_nxt.rem  = d_in.rem - trial;
         d_in_nxt.root = (d_in.root >> 1) + bit_v;
      end else begin
         d_in_nxt.rem  = d_in.rem;
         d_in_nxt.root = d_in.root >> 1;
      end
   end

   always_ff @(posedge clock) begin
      d_ff <= d_in_nxt;
   end

   assign d_out = d_ff;

endmodule

@@ rtl/core/geo_sector_containment_test.sv @@
`timescale 1ns / 1ps

// The request path has 43 + 2 x 24 register stages from req_data to rsp_data, and
// rsp_strobe is the last bit of a beat shift register of the same length.
// Throughput: one point per cycle; busy stays low, the pipeline of cells never stalls.
// The depth is set by the sin/cos rotation chain, the 32-cell square root chain and
// the half-angle vectoring chain in series. Reset (synchronous, active high) clears the
// beat pipeline and loads the register defaults; the receiver cannot stall.
module geo_sector_containment_test import gsct_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_data_type req_data,
   output logic         rsp_strobe,
   output rsp_data_type rsp_data,
   input  logic         csr_we,
   input  logic [2:0]   csr_index,
   input  logic [31:0]  csr_wdata
);

   localparam int CS = CORDIC_STAGES;
   localparam int SQ = SQRT_STAGES;
   localparam logic [39:0] RECIP_36K = 40'd119305;

   typedef struct packed {
      logic flip;
      logic zero;
      logic negq;
   } flag_type;

   // registers
   logic [30:0] center_lat_ff;
   logic [31:0] center_lon_ff;
   logic [24:0] radius_ff;
   logic [16:0] start_ff, end_ff;
   logic [15:0] heading_ff;
   logic        mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_lat_ff <= '0;
         center_lon_ff <= '0;
         radius_ff     <= '0;
         start_ff      <= '0;
         end_ff        <= FULL_CDEG;
         heading_ff    <= '0;
         mode_ff       <= 1'b0;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_CENTER_LAT:     center_lat_ff <= csr_wdata[30:0];
            CSR_CENTER_LON:     center_lon_ff <= csr_wdata;
            CSR_RADIUS_M:       radius_ff     <= csr_wdata[24:0];
            CSR_START_ANGLE:    start_ff      <= csr_wdata[16:0];
            CSR_END_ANGLE:      end_ff        <= csr_wdata[16:0];
            CSR_HEADING_OFFSET: heading_ff    <= csr_wdata[15:0];
            CSR_SECTOR_MODE:    mode_ff       <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // sector bounds, derived from the registers; the heading-relative bounds take two stages
   logic [17:0] sum_s_ff, sum_s_in, sum_e_ff, sum_e_in;
   logic [2:0]  q_s_ff, q_s_in, q_e_ff, q_e_in;
   logic [39:0] ps, pe;
   logic [17:0] rs, re;
   logic [16:0] ms_ff, ms_in, me_ff, me_in, s0_ff, s0_in, e0_ff, e0_in;
   logic        full_ff, full_in;

   always_comb begin
      sum_s_in = 18'(start_ff) + 18'(heading_ff);
      sum_e_in = 18'(end_ff) + 18'(heading_ff);
      ps       = 40'(sum_s_in) * RECIP_36K;
      pe       = 40'(sum_e_in) * RECIP_36K;
      q_s_in   = ps[34:32];
      q_e_in   = pe[34:32];
      rs       = sum_s_ff - 18'(q_s_ff) * 18'(FULL_CDEG);
      re       = sum_e_ff - 18'(q_e_ff) * 18'(FULL_CDEG);
      if (rs >= 18'(FULL_CDEG)) begin
         rs = rs - 18'(FULL_CDEG);
      end
      if (re >= 18'(FULL_CDEG)) begin
         re = re - 18'(FULL_CDEG);
      end
      ms_in   = rs[16:0];
      me_in   = re[16:0];
      s0_in   = (start_ff > FULL_CDEG) ? start_ff - FULL_CDEG : start_ff;
      e0_in   = (end_ff > FULL_CDEG) ? end_ff - FULL_CDEG : end_ff;
      full_in = 18'(end_ff) >= 18'(start_ff) + 18'(FULL_CDEG);
   end

   always_ff @(posedge clock) begin
      sum_s_ff <= sum_s_in;
      sum_e_ff <= sum_e_in;
      q_s_ff   <= q_s_in;
      q_e_ff   <= q_e_in;
      ms_ff    <= ms_in;
      me_ff    <= me_in;
      s0_ff    <= s0_in;
      e0_ff    <= e0_in;
      full_ff  <= full_in;
   end

   // beat tracking
   logic [LATENCY-1:0] vld_ff;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[LATENCY-2:0], start & !busy};
      end
   end

   // input and angle conversion
   req_data_type pt_ff;
   logic [31:0]  lat1b, lon1b, lat2b, lon2b;

   always_ff @(posedge clock) begin
      pt_ff <= req_data;
   end

   gsct_bin u_bin_lat1 (
      .clock (clock),
      .value ({center_lat_ff[30], center_lat_ff}),
      .angle (lat1b)
   );

   gsct_bin u_bin_lon1 (
      .clock (clock),
      .value (center_lon_ff),
      .angle (lon1b)
   );

   gsct_bin u_bin_lat2 (
      .clock (clock),
      .value ({pt_ff.point_lat[30], pt_ff.point_lat}),
      .angle (lat2b)
   );

   gsct_bin u_bin_lon2 (
      .clock (clock),
      .value (pt_ff.point_lon),
      .angle (lon2b)
   );

   // sin/cos lanes: center lat, point lat, half dlat, half dlon, dlon
   logic [31:0] ang [5];
   logic [31:0] a2 [5];
   logic [31:0] dphi, dlam;
   cordic_type  rot_init_ff [5];
   cordic_type  rot_init_in [5];
   flag_type    flg_init_ff [5];
   flag_type    flg_init_in [5];
   flag_type    flg_ff [5][CS];
   cordic_type  rot_w [5][CS+1];

   always_comb begin
      dphi   = lat2b - lat1b;
      dlam   = lon2b - lon1b;
      ang[0] = lat1b;
      ang[1] = lat2b;
      ang[2] = dphi >> 1;
      ang[3] = dlam >> 1;
      ang[4] = dlam;
      for (int l = 0; l < 5; l++) begin
         flg_init_in[l].flip = ((ang[l] + QUARTER) & HALF_TURN) != 32'd0;
         a2[l] = flg_init_in[l].flip ? ang[l] + HALF_TURN : ang[l];
         flg_init_in[l].zero = a2[l] == 32'd0;
         flg_init_in[l].negq = a2[l] == (32'd0 - QUARTER);
         rot_init_in[l].x    = GAIN_Q30;
         rot_init_in[l].y    = 64'sd0;
         rot_init_in[l].z    = 34'(signed'(a2[l]));
      end
   end

   always_ff @(posedge clock) begin
      for (int l = 0; l < 5; l++) begin
         rot_init_ff[l] <= rot_init_in[l];
         flg_init_ff[l] <= flg_init_in[l];
         flg_ff[l][0]   <= flg_init_ff[l];
         for (int k = 1; k < CS; k++) begin
            flg_ff[l][k] <= flg_ff[l][k-1];
         end
      end
   end

   for (genvar l = 0; l < 5; l++) begin : g_rot_lane
      assign rot_w[l][0] = rot_init_ff[l];
      for (genvar k = 0; k < CS; k++) begin : g_rot_cell
         gsct_cordic_cell u_cell (
            .clock     (clock),
            .rot_mode  (1'b1),
            .stage_idx (5'(k)),
            .d_in      (rot_w[l][k]),
            .d_out     (rot_w[l][k+1])
         );
      end
   end

   // sin/cos with exact axes and the half-turn fold undone
   logic signed [33:0] sin_ff [5];
   logic signed [33:0] sin_in [5];
   logic signed [33:0] cos_ff [5];
   logic signed [33:0] cos_in [5];
   logic signed [63:0] xs, ys;

   always_comb begin
      for (int l = 0; l < 5; l++) begin
         if (flg_ff[l][CS-1].zero) begin
            xs = ONE_Q30;
            ys = 64'sd0;
         end else if (flg_ff[l][CS-1].negq) begin
            xs = 64'sd0;
            ys = -ONE_Q30;
         end else begin
            xs = rot_w[l][CS].x;
            ys = rot_w[l][CS].y;
         end
         if (flg_ff[l][CS-1].flip) begin
            xs = -xs;
            ys = -ys;
         end
         sin_in[l] = ys[33:0];
         cos_in[l] = xs[33:0];
      end
   end

   always_ff @(posedge clock) begin
      for (int l = 0; l < 5; l++) begin
         sin_ff[l] <= sin_in[l];
         cos_ff[l] <= cos_in[l];
      end
   end

   // haversine term and bearing vector
   logic signed [63:0] shp2_ff, c1s2_ff, ysl_ff;
   logic signed [33:0] c1c2_ff, shl2_ff, s1c2_ff, cl_ff;
   logic signed [63:0] p_c1c2, p_shl2, p_s1c2;

   always_comb begin
      p_c1c2 = 64'(cos_ff[0]) * 64'(cos_ff[1]);
      p_shl2 = 64'(sin_ff[3]) * 64'(sin_ff[3]);
      p_s1c2 = 64'(sin_ff[0]) * 64'(cos_ff[1]);
      p_c1c2 = p_c1c2 >>> 30;
      p_shl2 = p_shl2 >>> 30;
      p_s1c2 = p_s1c2 >>> 30;
   end

   always_ff @(posedge clock) begin
      shp2_ff <= 64'(sin_ff[2]) * 64'(sin_ff[2]);
      c1c2_ff <= p_c1c2[33:0];
      shl2_ff <= p_shl2[33:0];
      c1s2_ff <= 64'(cos_ff[0]) * 64'(sin_ff[1]);
      s1c2_ff <= p_s1c2[33:0];
      ysl_ff  <= 64'(sin_ff[4]) * 64'(cos_ff[1]);
      cl_ff   <= cos_ff[4];
   end

   logic signed [63:0] asum;
   logic [60:0]        a_ff, a_in;
   logic signed [63:0] bx_ff, by_ff;

   always_comb begin
      asum = shp2_ff + 64'(c1c2_ff) * 64'(shl2_ff);
      if (asum < 64'sd0) begin
         a_in = '0;
      end else if (asum > (64'sd1 <<< 60)) begin
         a_in = 61'h1000_0000_0000_0000;
      end else begin
         a_in = asum[60:0];
      end
   end

   always_ff @(posedge clock) begin
      a_ff  <= a_in;
      bx_ff <= c1s2_ff - 64'(s1c2_ff) * 64'(cl_ff);
      by_ff <= ysl_ff;
   end

   // root chains and bearing vectoring chain
   sqrt_type   sqa_ff, sqn_ff;
   cordic_type bv_ff, bv_in;
   sqrt_type   sqa_w [SQ+1];
   sqrt_type   sqn_w [SQ+1];
   cordic_type bv_w [CS+1];

   always_comb begin
      if (bx_ff < 64'sd0) begin
         bv_in.x = -bx_ff;
         bv_in.y = -by_ff;
         bv_in.z = 34'sh0_8000_0000;
      end else begin
         bv_in.x = bx_ff;
         bv_in.y = by_ff;
         bv_in.z = 34'sd0;
      end
   end

   always_ff @(posedge clock) begin
      sqa_ff.rem  <= 64'(a_ff);
      sqa_ff.root <= '0;
      sqn_ff.rem  <= 64'h1000_0000_0000_0000 - 64'(a_ff);
      sqn_ff.root <= '0;
      bv_ff       <= bv_in;
   end

   assign sqa_w[0] = sqa_ff;
   assign sqn_w[0] = sqn_ff;
   assign bv_w[0]  = bv_ff;

   for (genvar j = 0; j < SQ; j++) begin : g_sqrt_cell
      gsct_sqrt_cell u_sqa (
         .clock     (clock),
         .stage_idx (5'(SQ - 1 - j)),
         .d_in      (sqa_w[j]),
         .d_out     (sqa_w[j+1])
      );
      gsct_sqrt_cell u_sqn (
         .clock     (clock),
         .stage_idx (5'(SQ - 1 - j)),
         .d_in      (sqn_w[j]),
         .d_out     (sqn_w[j+1])
      );
   end

   for (genvar k = 0; k < CS; k++) begin : g_brg_cell
      gsct_cordic_cell u_cell (
         .clock     (clock),
         .rot_mode  (1'b0),
         .stage_idx (5'(k)),
         .d_in      (bv_w[k]),
         .d_out     (bv_w[k+1])
      );
   end

   // bearing angle waits for the root and half-angle chains
   logic [31:0] bz_ff [SQ];

   always_ff @(posedge clock) begin
      bz_ff[0] <= bv_w[CS].z[31:0];
      for (int k = 1; k < SQ; k++) begin
         bz_ff[k] <= bz_ff[k-1];
      end
   end

   // half central angle
   cordic_type hv_w [CS+1];

   always_comb begin
      hv_w[0].x = signed'(sqn_w[SQ].root);
      hv_w[0].y = signed'(sqa_w[SQ].root);
      hv_w[0].z = 34'sd0;
   end

   for (genvar k = 0; k < CS; k++) begin : g_half_cell
      gsct_cordic_cell u_cell (
         .clock     (clock),
         .rot_mode  (1'b0),
         .stage_idx (5'(k)),
         .d_in      (hv_w[k]),
         .d_out     (hv_w[k+1])
      );
   end

   // scaling
   logic [31:0] hz, half;
   logic [61:0] rp_ff;
   logic [47:0] bp_ff;

   always_comb begin
      hz = hv_w[CS].z[31:0];
      if (hz >= HALF_TURN) begin
         half = '0;
      end else if (hz > QUARTER) begin
         half = QUARTER;
      end else begin
         half = hz;
      end
   end

   always_ff @(posedge clock) begin
      rp_ff <= 62'(half) * 62'(ARC_SCALE);
      bp_ff <= 48'(bz_ff[SQ-1]) * 48'(FULL_CDEG);
   end

   // containment
   logic [61:0]  rr;
   logic [47:0]  br;
   logic [16:0]  bb;
   logic [24:0]  range_v;
   logic         inc, ins;
   rsp_data_type rsp_ff, rsp_in;

   always_comb begin
      rr      = rp_ff + 62'h8_0000_0000;
      range_v = rr[60:36];
      br      = bp_ff + 48'h8000_0000;
      bb      = br[48-1:32] >= 16'(FULL_CDEG) ? 17'd0 : {1'b0, br[47:32]};
      inc     = range_v <= radius_ff;
      if (!mode_ff) begin
         // wrapped absolute sector excludes both bounds
         ins = (s0_ff > e0_ff) ? (bb > s0_ff || bb < e0_ff)
                               : (bb >= s0_ff && bb <= e0_ff);
      end else if (full_ff) begin
         ins = 1'b1;
      end else begin
         ins = (ms_ff > me_ff) ? (bb >= ms_ff || bb <= me_ff)
                               : (bb >= ms_ff && bb <= me_ff);
      end
      rsp_in.range_m      = range_v;
      rsp_in.bearing_cdeg = bb[15:0];
      rsp_in.in_circle    = inc;
      rsp_in.in_sector    = inc && ins;
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = vld_ff[LATENCY-1];
   assign rsp_data   = rsp_ff;

endmodule
